// ===== rtl/core/wtvg_pkg.sv =====
package wtvg_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned PosW       = 24;
  localparam int unsigned MagW       = 24;
  localparam int unsigned ProdW      = 2 * MagW;
  localparam int unsigned SqW        = 50;
  localparam int unsigned RootW      = SqW / 2;
  localparam int unsigned NumW       = 42;
  localparam int unsigned VelW       = 17;
  localparam int unsigned SpdW       = 16;
  localparam int unsigned AddrW      = 4;

  localparam logic [SpdW-1:0] SpeedReset  = 16'd307;
  localparam logic [SpdW-1:0] RadiusReset = 16'd51;
  localparam logic [IdxW-1:0] LastReset   = 4'd12;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_SPEED  = 2'd0,
    REG_RADIUS = 2'd1,
    REG_LAST   = 2'd2,
    REG_NONE   = 2'd3
  } reg_e;

  function automatic logic signed [PosW-1:0] path_init(input logic [IdxW-1:0] i);
    logic signed [PosW-1:0] v;
    case (i)
      4'd1, 4'd11: v = 24'sd512;
      4'd2, 4'd10: v = 24'sd1024;
      4'd3, 4'd9:  v = 24'sd1536;
      4'd4, 4'd8:  v = 24'sd2048;
      4'd5, 4'd7:  v = 24'sd2560;
      4'd6:        v = 24'sd3072;
      default:     v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [PosW-1:0] sat_add(input logic signed [PosW-1:0] a,
                                                     input logic signed [PosW-1:0] b);
    logic signed [PosW:0] s;
    s = {a[PosW-1], a} + {b[PosW-1], b};
    if (s[PosW] != s[PosW-1]) begin
      return {s[PosW], {(PosW-1){~s[PosW]}}};
    end
    return s[PosW-1:0];
  endfunction

  function automatic logic [MagW-1:0] mag(input logic signed [PosW:0] v);
    logic signed [PosW:0] n;
    n = -v;
    return v[PosW] ? n[MagW-1:0] : v[MagW-1:0];
  endfunction

endpackage

// ===== rtl/core/wtvg_if.sv =====
interface wtvg_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic signed [wtvg_pkg::PosW-1:0]    pos_x;
  logic signed [wtvg_pkg::PosW-1:0]    pos_y;
  logic [wtvg_pkg::IdxW-1:0]           entry_index;
  logic signed [wtvg_pkg::PosW-1:0]    entry_dx;
  logic signed [wtvg_pkg::PosW-1:0]    entry_dy;
  modport source (output valid, kind, pos_x, pos_y, entry_index, entry_dx, entry_dy,
                  input ready);
  modport sink (input valid, kind, pos_x, pos_y, entry_index, entry_dx, entry_dy,
                output ready);
endinterface

interface wtvg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [wtvg_pkg::VelW-1:0]    vel_x;
  logic signed [wtvg_pkg::VelW-1:0]    vel_y;
  logic signed [wtvg_pkg::PosW-1:0]    goal_x;
  logic signed [wtvg_pkg::PosW-1:0]    goal_y;
  logic [wtvg_pkg::IdxW-1:0]           goal_index;
  logic                                advanced;
  logic                                zero_length;
  modport source (output valid, vel_x, vel_y, goal_x, goal_y, goal_index, advanced,
                  zero_length, input ready);
  modport sink (input valid, vel_x, vel_y, goal_x, goal_y, goal_index, advanced,
                zero_length, output ready);
endinterface

// ===== rtl/core/waypoint_table_velocity_guidance_top.sv =====
// Waypoint table velocity guidance.
// Input channel in_i carries one item per handshake: a position sample, a table
// entry write or a path restart. Output channel out_o gives one result per
// position sample: velocity, current goal, goal index and two flags.
// Entry writes and restarts give no result.
// A position sample runs through the bit-serial multiplier (up to seven
// products), the square root (one result bit per cycle) and the divider
// (one quotient bit per cycle, two divisions). The first sample after reset
// or restart skips the arrival check.
// Registers over APB (byte offsets): 0x0 cruise_speed, 0x4 arrive_radius, 0x8 last_entry.
// Reset restores register defaults and the built-in path table and
// forgets the origin. A finished result waits in the output register while
// the receiver stalls; the next item is still taken, and its result holds
// in the core until the output register is free.
module waypoint_table_velocity_guidance_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  wtvg_in_if.sink                        in_i,
  wtvg_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wtvg_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  localparam int unsigned PW = wtvg_pkg::PosW;
  localparam int unsigned IW = wtvg_pkg::IdxW;
  localparam int unsigned MW = wtvg_pkg::MagW;
  localparam int unsigned VW = wtvg_pkg::VelW;
  localparam int unsigned SP = wtvg_pkg::SpdW;
  localparam int unsigned SW = wtvg_pkg::SqW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ARR_X, ST_ARR_Y, ST_ARR_R, ST_RETGT, ST_SQ_X, ST_SQ_Y, ST_ROOT,
    ST_NUM_X, ST_DIV_X, ST_NUM_Y, ST_DIV_Y, ST_EMIT
  } state_e;

  state_e state_q;
  logic   go_q;

  logic [SP-1:0] speed_q, radius_q;
  logic [IW-1:0] last_q;

  logic                 started_q;
  logic [IW-1:0]        idx_q;
  logic signed [PW-1:0] org_x_q, org_y_q, tgt_x_q, tgt_y_q, px_q, py_q;
  logic signed [PW-1:0] tab_x_q [wtvg_pkg::TableDepth];
  logic signed [PW-1:0] tab_y_q [wtvg_pkg::TableDepth];

  logic [SW-1:0]              acc_q;
  logic [wtvg_pkg::RootW-1:0] len_q;
  logic signed [VW-1:0]       vx_q, vy_q;
  logic                       adv_q, zero_q;

  logic                 ov_q, oadv_q, ozero_q;
  logic signed [VW-1:0] ovx_q, ovy_q;
  logic signed [PW-1:0] ogx_q, ogy_q;
  logic [IW-1:0]        oidx_q;

  logic signed [PW:0]   ex_x, ex_y, dx, dy;
  logic [MW-1:0]        mul_a, mul_b;
  logic [wtvg_pkg::ProdW-1:0] prod;
  logic                 mul_done, sqrt_done, div_done;
  logic [wtvg_pkg::RootW-1:0] root;
  logic [VW-1:0]        quo;
  logic [wtvg_pkg::NumW-1:0]  div_num;
  logic [IW:0]          nxt;
  logic                 near, mul_start;
  logic                 cfg_wr;
  logic [1:0]           cfg_sel;

  assign ex_x = {px_q[PW-1], px_q} - {tgt_x_q[PW-1], tgt_x_q};
  assign ex_y = {py_q[PW-1], py_q} - {tgt_y_q[PW-1], tgt_y_q};
  assign dx   = {tgt_x_q[PW-1], tgt_x_q} - {px_q[PW-1], px_q};
  assign dy   = {tgt_y_q[PW-1], tgt_y_q} - {py_q[PW-1], py_q};

  assign near = (wtvg_pkg::mag(ex_x) < MW'(65536)) && (wtvg_pkg::mag(ex_y) < MW'(65536));
  assign nxt  = {1'b0, idx_q} + {{IW{1'b0}}, 1'b1};
  assign div_num = prod[wtvg_pkg::NumW-1:0]
                 + {{(wtvg_pkg::NumW-wtvg_pkg::RootW+1){1'b0}},
                    len_q[wtvg_pkg::RootW-1:1]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_ARR_X: begin
        mul_a = wtvg_pkg::mag(ex_x);
        mul_b = mul_a;
      end
      ST_ARR_Y: begin
        mul_a = wtvg_pkg::mag(ex_y);
        mul_b = mul_a;
      end
      ST_ARR_R: begin
        mul_a = {{(MW-SP){1'b0}}, radius_q};
        mul_b = mul_a;
      end
      ST_SQ_X: begin
        mul_a = wtvg_pkg::mag(dx);
        mul_b = mul_a;
      end
      ST_SQ_Y: begin
        mul_a = wtvg_pkg::mag(dy);
        mul_b = mul_a;
      end
      ST_NUM_X: begin
        mul_a = wtvg_pkg::mag(dx);
        mul_b = {{(MW-SP){1'b0}}, speed_q};
      end
      ST_NUM_Y: begin
        mul_a = wtvg_pkg::mag(dy);
        mul_b = {{(MW-SP){1'b0}}, speed_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start = go_q && (state_q == ST_ARR_X || state_q == ST_ARR_Y ||
                              state_q == ST_ARR_R || state_q == ST_SQ_X ||
                              state_q == ST_SQ_Y || state_q == ST_NUM_X ||
                              state_q == ST_NUM_Y);

  wtvg_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  wtvg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q && state_q == ST_ROOT),
    .val_i   (acc_q),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  wtvg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (go_q && (state_q == ST_DIV_X || state_q == ST_DIV_Y)),
    .num_i   (div_num),
    .den_i   (len_q),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = paddr[3:2];

  always_comb begin
    unique case (cfg_sel)
      wtvg_pkg::REG_SPEED:  prdata = {{(32-SP){1'b0}}, speed_q};
      wtvg_pkg::REG_RADIUS: prdata = {{(32-SP){1'b0}}, radius_q};
      wtvg_pkg::REG_LAST:   prdata = {{(32-IW){1'b0}}, last_q};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= wtvg_pkg::SpeedReset;
      radius_q <= wtvg_pkg::RadiusReset;
      last_q   <= wtvg_pkg::LastReset;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        wtvg_pkg::REG_SPEED:  speed_q  <= pwdata[SP-1:0];
        wtvg_pkg::REG_RADIUS: radius_q <= pwdata[SP-1:0];
        wtvg_pkg::REG_LAST:   last_q   <= pwdata[IW-1:0];
        default: ;
      endcase
    end
  end

  // path table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wtvg_pkg::TableDepth; i++) begin
        tab_x_q[i] <= wtvg_pkg::path_init(IW'(i));
        tab_y_q[i] <= wtvg_pkg::path_init(IW'(i));
      end
    end else if (in_i.valid && in_i.ready && in_i.kind == wtvg_pkg::KIND_ENTRY) begin
      tab_x_q[in_i.entry_index] <= in_i.entry_dx;
      tab_y_q[in_i.entry_index] <= in_i.entry_dy;
    end
  end

  assign in_i.ready = (state_q == ST_IDLE);

  assign out_o.valid       = ov_q;
  assign out_o.vel_x       = ovx_q;
  assign out_o.vel_y       = ovy_q;
  assign out_o.goal_x      = ogx_q;
  assign out_o.goal_y      = ogy_q;
  assign out_o.goal_index  = oidx_q;
  assign out_o.advanced    = oadv_q;
  assign out_o.zero_length = ozero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      go_q      <= 1'b0;
      started_q <= 1'b0;
      idx_q     <= '0;
      org_x_q   <= '0;
      org_y_q   <= '0;
      tgt_x_q   <= '0;
      tgt_y_q   <= '0;
      ov_q      <= 1'b0;
    end else begin
      if (ov_q && out_o.ready && state_q != ST_EMIT) begin
        ov_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          go_q <= in_i.valid && (in_i.kind == wtvg_pkg::KIND_SAMPLE) && started_q;
          if (in_i.valid) begin
            case (in_i.kind)
              wtvg_pkg::KIND_SAMPLE: begin
                px_q   <= in_i.pos_x;
                py_q   <= in_i.pos_y;
                adv_q  <= 1'b0;
                zero_q <= 1'b0;
                vx_q   <= '0;
                vy_q   <= '0;
                if (!started_q) begin
                  org_x_q   <= in_i.pos_x;
                  org_y_q   <= in_i.pos_y;
                  idx_q     <= IW'(1);
                  started_q <= 1'b1;
                  state_q   <= ST_RETGT;
                end else begin
                  state_q <= ST_ARR_X;
                end
              end
              wtvg_pkg::KIND_RESTART: begin
                started_q <= 1'b0;
                idx_q     <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_ARR_X: begin
          go_q <= mul_done;
          if (mul_done) begin
            acc_q   <= SW'(prod);
            state_q <= ST_ARR_Y;
          end
        end
        ST_ARR_Y: begin
          go_q <= mul_done;
          if (mul_done) begin
            acc_q   <= acc_q + SW'(prod);
            state_q <= ST_ARR_R;
          end
        end
        ST_ARR_R: begin
          go_q <= mul_done && !(near && acc_q < SW'(prod));
          if (mul_done) begin
            if (near && acc_q < SW'(prod)) begin
              idx_q   <= (nxt > {1'b0, last_q}) ? '0 : nxt[IW-1:0];
              adv_q   <= 1'b1;
              state_q <= ST_RETGT;
            end else begin
              state_q <= ST_SQ_X;
            end
          end
        end
        ST_RETGT: begin
          tgt_x_q <= wtvg_pkg::sat_add(org_x_q, tab_x_q[idx_q]);
          tgt_y_q <= wtvg_pkg::sat_add(org_y_q, tab_y_q[idx_q]);
          go_q    <= 1'b1;
          state_q <= ST_SQ_X;
        end
        ST_SQ_X: begin
          go_q <= mul_done;
          if (mul_done) begin
            acc_q   <= SW'(prod);
            state_q <= ST_SQ_Y;
          end
        end
        ST_SQ_Y: begin
          go_q <= mul_done;
          if (mul_done) begin
            acc_q   <= acc_q + SW'(prod);
            state_q <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          go_q <= sqrt_done && (root != '0);
          if (sqrt_done) begin
            len_q <= root;
            if (root == '0) begin
              zero_q  <= 1'b1;
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_NUM_X;
            end
          end
        end
        ST_NUM_X: begin
          go_q <= mul_done;
          if (mul_done) begin
            state_q <= ST_DIV_X;
          end
        end
        ST_DIV_X: begin
          go_q <= div_done;
          if (div_done) begin
            vx_q    <= dx[PW] ? -$signed(quo) : $signed(quo);
            state_q <= ST_NUM_Y;
          end
        end
        ST_NUM_Y: begin
          go_q <= mul_done;
          if (mul_done) begin
            state_q <= ST_DIV_Y;
          end
        end
        ST_DIV_Y: begin
          go_q <= 1'b0;
          if (div_done) begin
            vy_q    <= dy[PW] ? -$signed(quo) : $signed(quo);
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          go_q <= 1'b0;
          if (!ov_q || out_o.ready) begin
            ov_q    <= 1'b1;
            ovx_q   <= vx_q;
            ovy_q   <= vy_q;
            ogx_q   <= tgt_x_q;
            ogy_q   <= tgt_y_q;
            oidx_q  <= idx_q;
            oadv_q  <= adv_q;
            ozero_q <= zero_q;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          go_q    <= 1'b0;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== rtl/core/wtvg_mul.sv =====
module wtvg_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wtvg_pkg::MagW-1:0]    a_i,
  input  logic [wtvg_pkg::MagW-1:0]    b_i,
  output logic [wtvg_pkg::ProdW-1:0]   prod_o,
  output logic                         done_o
);
  localparam int unsigned W = wtvg_pkg::MagW;
  localparam int unsigned PW = wtvg_pkg::ProdW;

  logic [W-1:0]  a_q;
  logic [PW-1:0] p_q;
  logic [4:0]    cnt_q;
  logic          busy_q;
  logic [W:0]    sum;

  assign sum    = {1'b0, p_q[PW-1:W]} + (p_q[0] ? {1'b0, a_q} : '0);
  assign prod_o = p_q;
  assign done_o = busy_q && (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'(W);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 5'd1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{W{1'b0}}, b_i};
    end else if (busy_q && cnt_q != '0) begin
      p_q <= {sum, p_q[W-1:1]};
    end
  end
endmodule

// ===== rtl/core/wtvg_sqrt.sv =====
module wtvg_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wtvg_pkg::SqW-1:0]     val_i,
  output logic [wtvg_pkg::RootW-1:0]   root_o,
  output logic                         done_o
);
  localparam int unsigned SW = wtvg_pkg::SqW;
  localparam int unsigned RW = wtvg_pkg::RootW;

  logic [SW-1:0] v_q;
  logic [RW+1:0] rem_q;
  logic [RW-1:0] root_q;
  logic [4:0]    cnt_q;
  logic          busy_q;
  logic [RW+3:0] t, trial, diff;
  logic          ge;

  assign t      = {rem_q, v_q[SW-1:SW-2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = t >= trial;
  assign diff   = t - trial;
  assign root_o = root_q;
  assign done_o = busy_q && (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'(RW);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 5'd1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      v_q    <= {v_q[SW-3:0], 2'b00};
      rem_q  <= ge ? diff[RW+1:0] : t[RW+1:0];
      root_q <= {root_q[RW-2:0], ge};
    end
  end
endmodule

// ===== rtl/core/wtvg_div.sv =====
module wtvg_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wtvg_pkg::NumW-1:0]    num_i,
  input  logic [wtvg_pkg::RootW-1:0]   den_i,
  output logic [wtvg_pkg::VelW-1:0]    quo_o,
  output logic                         done_o
);
  localparam int unsigned NW = wtvg_pkg::NumW;
  localparam int unsigned DW = wtvg_pkg::RootW;

  logic [NW-1:0] n_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] d_q;
  logic [5:0]    cnt_q;
  logic          busy_q;
  logic [DW:0]   t, diff;
  logic          ge;

  assign t      = {rem_q, n_q[NW-1]};
  assign ge     = t >= {1'b0, d_q};
  assign diff   = t - {1'b0, d_q};
  assign quo_o  = n_q[wtvg_pkg::VelW-1:0];
  assign done_o = busy_q && (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'(NW);
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 6'd1;
      end else begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      d_q   <= den_i;
      rem_q <= '0;
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= ge ? diff[DW-1:0] : t[DW-1:0];
      n_q   <= {n_q[NW-2:0], ge};
    end
  end
endmodule
